[sv/mstk_pkg.sv]
package mstk_pkg;

   localparam int NODE_W   = 5;
   localparam int WEIGHT_W = 16;
   localparam int NCOUNT_W = 6;
   localparam int CIDX_W   = 8;

   localparam logic [NCOUNT_W-1:0] NODE_COUNT_RESET = 6'd32;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_RUN  = 1'b1;

   typedef struct packed {
      logic                opcode;
      logic [NODE_W-1:0]   end_a;
      logic [NODE_W-1:0]   end_b;
      logic [WEIGHT_W-1:0] weight;
   } req_type;

   typedef struct packed {
      logic [CIDX_W-1:0]   chosen_index;
      logic [NODE_W-1:0]   chosen_a;
      logic [NODE_W-1:0]   chosen_b;
      logic [WEIGHT_W-1:0] chosen_weight;
      logic                empty_res;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic [NODE_W-1:0]   a;
      logic [NODE_W-1:0]   b;
      logic [WEIGHT_W-1:0] w;
   } edge_type;

   typedef struct packed {
      logic              init;
      logic              merge;
      logic [NODE_W-1:0] from_label;
      logic [NODE_W-1:0] to_label;
   } lbl_cmd_type;

endpackage

[sv/minimum_spanning_tree_kruskal.sv]
// Channel | Ports                         | Handshake
// --------+-------------------------------+--------------------------------
// request | req, start, busy              | beat taken when start && !busy
// result  | rsp, rsp_valid                | one cycle strobe, no stall
// config  | csr_we, csr_wdata             | written when csr_we
// A load leaves busy low, and the next beat may follow at once.
// A run holds busy while it sorts and then walks the E stored edges. The sort inserts
// each edge into the order memory, which has one write port and one read port, with
// P shifts in all (at most E*(E-1)/2); the walk reads every edge in weight order and
// looks up the labels of each edge with both endpoints below the node count.
// Synchronous reset clears the edge count and sets each node label to its own index. Results cannot be stalled.
module minimum_spanning_tree_kruskal
   import mstk_pkg::*;
#(
   parameter int MAX_NODES = 32,
   parameter int MAX_EDGES = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  req_type             req,
   output logic                rsp_valid,
   output rsp_type             rsp,
   input  logic                csr_we,
   input  logic [NCOUNT_W-1:0] csr_wdata
);
   localparam int IW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int CW  = $clog2(MAX_EDGES + 1);
   localparam int LN  = (MAX_NODES < 32) ? MAX_NODES : 32;
   localparam int LIW = (LN > 1) ? $clog2(LN) : 1;
   localparam int OW  = WEIGHT_W + IW;

   typedef enum logic [3:0] {
      S_IDLE, S_INIT, S_SRT_EDGE, S_SRT_CUR, S_SRT_RD, S_SRT_CMP,
      S_WLK_RD, S_WLK_IDX, S_WLK_EDGE, S_WLK_LA, S_WLK_LB, S_DONE
   } state_type;

   state_type             state_ff;
   logic [NCOUNT_W-1:0]   node_count_ff;
   logic [CW-1:0]         count_ff, i_ff, j_ff, k_ff;
   logic [WEIGHT_W-1:0]   wcur_ff;
   edge_type              cand_ff;
   logic [IW-1:0]         cand_idx_ff;
   logic [NODE_W-1:0]     la_ff;
   rsp_type               pend_ff;
   logic                  have_pend_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   logic                  e_wr, e_rd;
   logic [IW-1:0]         e_wa, e_ra;
   edge_type              e_wd, e_q;
   logic                  o_wr, o_rd;
   logic [IW-1:0]         o_wa, o_ra;
   logic [OW-1:0]         o_wd, o_q;
   lbl_cmd_type           lcmd;
   logic [LIW-1:0]        l_addr;
   logic [NODE_W-1:0]     l_q;
   logic                  in_range;
   logic                  w_gt;

   mstk_ram #(.DEPTH(MAX_EDGES), .WIDTH($bits(edge_type))) u_edges (
      .clock(clock), .wr_en(e_wr), .wr_addr(e_wa), .wr_data(e_wd),
      .rd_en(e_rd), .rd_addr(e_ra), .rd_data(e_q)
   );

   mstk_ram #(.DEPTH(MAX_EDGES), .WIDTH(OW)) u_order (
      .clock(clock), .wr_en(o_wr), .wr_addr(o_wa), .wr_data(o_wd),
      .rd_en(o_rd), .rd_addr(o_ra), .rd_data(o_q)
   );

   mstk_labels #(.NUM(LN)) u_labels (
      .clock(clock), .reset(reset), .cmd(lcmd), .rd_addr(l_addr), .rd_label(l_q)
   );

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   assign w_gt = o_q[IW +: WEIGHT_W] > wcur_ff;
   assign in_range = ({2'b00, e_q.a} < 7'(MAX_NODES)) && ({1'b0, e_q.a} < {1'b0, node_count_ff})
                  && ({2'b00, e_q.b} < 7'(MAX_NODES)) && ({1'b0, e_q.b} < {1'b0, node_count_ff});

   always_comb begin
      e_wr = 1'b0;
      e_wa = count_ff[IW-1:0];
      e_wd = '{a: req.end_a, b: req.end_b, w: req.weight};
      e_rd = 1'b0;
      e_ra = i_ff[IW-1:0];
      o_wr = 1'b0;
      o_wa = j_ff[IW-1:0];
      o_wd = {wcur_ff, i_ff[IW-1:0]};
      o_rd = 1'b0;
      o_ra = k_ff[IW-1:0];
      lcmd = '{init: 1'b0, merge: 1'b0, from_label: l_q, to_label: la_ff};
      l_addr = cand_ff.a[LIW-1:0];
      case (state_ff)
         S_IDLE: begin
            e_wr = start && req.opcode == OP_LOAD && count_ff < CW'(MAX_EDGES);
         end
         S_INIT: lcmd.init = 1'b1;
         S_SRT_EDGE: e_rd = 1'b1;
         S_SRT_RD: begin
            if (j_ff == '0) begin
               o_wr = 1'b1;
            end else begin
               o_rd = 1'b1;
               o_ra = IW'(j_ff - 1'b1);
            end
         end
         S_SRT_CMP: begin
            o_wr = 1'b1;
            if (w_gt) begin
               o_wd = o_q;
            end
         end
         S_WLK_RD: o_rd = 1'b1;
         S_WLK_IDX: begin
            e_rd = 1'b1;
            e_ra = o_q[IW-1:0];
         end
         S_WLK_LB: begin
            l_addr = cand_ff.b[LIW-1:0];
            lcmd.merge = (l_q != la_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         node_count_ff <= NODE_COUNT_RESET;
         count_ff      <= '0;
         have_pend_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == S_DONE)
                      || (state_ff == S_WLK_LB && l_q != la_ff && have_pend_ff);
         if (csr_we) begin
            node_count_ff <= csr_wdata;
         end
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  if (req.opcode == OP_RUN) begin
                     state_ff <= S_INIT;
                  end else if (count_ff < CW'(MAX_EDGES)) begin
                     count_ff <= count_ff + 1'b1;
                  end
               end
            end
            S_INIT: begin
               i_ff         <= '0;
               k_ff         <= '0;
               have_pend_ff <= 1'b0;
               state_ff     <= (count_ff == '0) ? S_DONE : S_SRT_EDGE;
            end
            S_SRT_EDGE: state_ff <= S_SRT_CUR;
            S_SRT_CUR: begin
               wcur_ff  <= e_q.w;
               j_ff     <= i_ff;
               state_ff <= S_SRT_RD;
            end
            S_SRT_RD: begin
               if (j_ff == '0) begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= (i_ff + 1'b1 == count_ff) ? S_WLK_RD : S_SRT_EDGE;
               end else begin
                  state_ff <= S_SRT_CMP;
               end
            end
            S_SRT_CMP: begin
               if (w_gt) begin
                  j_ff     <= j_ff - 1'b1;
                  state_ff <= S_SRT_RD;
               end else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= (i_ff + 1'b1 == count_ff) ? S_WLK_RD : S_SRT_EDGE;
               end
            end
            S_WLK_RD: state_ff <= S_WLK_IDX;
            S_WLK_IDX: begin
               cand_idx_ff <= o_q[IW-1:0];
               state_ff    <= S_WLK_EDGE;
            end
            S_WLK_EDGE: begin
               cand_ff <= e_q;
               if (in_range) begin
                  state_ff <= S_WLK_LA;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= (k_ff + 1'b1 == count_ff) ? S_DONE : S_WLK_RD;
               end
            end
            S_WLK_LA: begin
               la_ff    <= l_q;
               state_ff <= S_WLK_LB;
            end
            S_WLK_LB: begin
               if (l_q != la_ff) begin
                  if (have_pend_ff) begin
                     rsp_ff <= pend_ff;
                  end
                  have_pend_ff <= 1'b1;
                  pend_ff      <= '{chosen_index: CIDX_W'(cand_idx_ff), chosen_a: cand_ff.a,
                                    chosen_b: cand_ff.b, chosen_weight: cand_ff.w,
                                    empty_res: 1'b0, last: 1'b0};
               end
               k_ff     <= k_ff + 1'b1;
               state_ff <= (k_ff + 1'b1 == count_ff) ? S_DONE : S_WLK_RD;
            end
            S_DONE: begin
               if (have_pend_ff) begin
                  rsp_ff <= {pend_ff[$bits(rsp_type)-1:1], 1'b1};
               end else begin
                  rsp_ff <= '{chosen_index: '0, chosen_a: '0, chosen_b: '0,
                              chosen_weight: '0, empty_res: 1'b1, last: 1'b1};
               end
               have_pend_ff <= 1'b0;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req.opcode == OP_RUN |=> busy)
      else $error("run beat did not raise busy");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.empty_res |-> rsp.last)
      else $error("empty result without last");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.last |-> !busy)
      else $error("last result while run still active");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_EDGES))
      else $error("edge count overflow");
endmodule

[sv/mstk_ram.sv]
module mstk_ram
   import mstk_pkg::*;
#(
   parameter int DEPTH = 256,
   parameter int WIDTH = 26,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   output logic [WIDTH-1:0]     rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[sv/mstk_labels.sv]
module mstk_labels
   import mstk_pkg::*;
#(
   parameter int NUM = 32,
   localparam int LIW = (NUM > 1) ? $clog2(NUM) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  lbl_cmd_type       cmd,
   input  logic [LIW-1:0]    rd_addr,
   output logic [NODE_W-1:0] rd_label
);
   logic [NODE_W-1:0] label_ff [NUM];

   always_ff @(posedge clock) begin
      for (int n = 0; n < NUM; n++) begin
         if (reset || cmd.init) begin
            label_ff[n] <= NODE_W'(n);
         end else if (cmd.merge && label_ff[n] == cmd.from_label) begin
            label_ff[n] <= cmd.to_label;
         end
      end
   end

   assign rd_label = label_ff[rd_addr];
endmodule

[tb/minimum_spanning_tree_kruskal_test.sv]
module minimum_spanning_tree_kruskal_test;
   import mstk_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int EDGE_CAP   = 256;
   localparam int NODE_CAP   = 32;
   localparam int CYCLE_LIMIT = 4_000_000;

   class mst_scoreboard;
      edge_type              edges [EDGE_CAP];
      int unsigned           n_edges;
      logic [NCOUNT_W-1:0]   nodes;
      rsp_type               pending [$];
      int                    errors;
      int                    results;
      int                    runs;
      int                    ignored_loads;

      function new();
         n_edges = 0;
         nodes = NODE_COUNT_RESET;
         errors = 0;
         results = 0;
         runs = 0;
         ignored_loads = 0;
      endfunction

      function void set_nodes(logic [NCOUNT_W-1:0] v);
         nodes = v;
      endfunction

      function void note(req_type r);
         int                ord [$];
         int                j;
         int                lim;
         logic [NODE_W-1:0] lbl [NODE_CAP];
         logic [NODE_W-1:0] la, lb;
         edge_type          e;
         rsp_type           tree [$];
         rsp_type           t;
         if (r.opcode == OP_LOAD) begin
            if (n_edges < EDGE_CAP) begin
               edges[n_edges] = '{a: r.end_a, b: r.end_b, w: r.weight};
               n_edges++;
            end else begin
               ignored_loads++;
            end
            return;
         end
         runs++;
         for (int i = 0; i < n_edges; i++) begin
            j = ord.size();
            while (j > 0 && edges[ord[j-1]].w > edges[i].w) j--;
            ord.insert(j, i);
         end
         lim = (nodes < NODE_CAP) ? nodes : NODE_CAP;
         for (int i = 0; i < NODE_CAP; i++) lbl[i] = i[NODE_W-1:0];
         foreach (ord[k]) begin
            e = edges[ord[k]];
            if (e.a >= lim || e.b >= lim) continue;
            la = lbl[e.a];
            lb = lbl[e.b];
            if (la == lb) continue;
            for (int i = 0; i < NODE_CAP; i++) if (lbl[i] == lb) lbl[i] = la;
            t = '0;
            t.chosen_index  = ord[k][CIDX_W-1:0];
            t.chosen_a      = e.a;
            t.chosen_b      = e.b;
            t.chosen_weight = e.w;
            tree.push_back(t);
         end
         if (tree.size() == 0) begin
            t = '0;
            t.empty_res = 1'b1;
            t.last = 1'b1;
            tree.push_back(t);
         end else begin
            tree[tree.size()-1].last = 1'b1;
         end
         foreach (tree[k]) pending.push_back(tree[k]);
      endfunction

      function void check(rsp_type got);
         rsp_type want;
         results++;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result beat %p", got);
            return;
         end
         want = pending.pop_front();
         if (got.chosen_index !== want.chosen_index || got.chosen_a !== want.chosen_a ||
             got.chosen_b !== want.chosen_b || got.chosen_weight !== want.chosen_weight ||
             got.empty_res !== want.empty_res || got.last !== want.last) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: expected %p actual %p", want, got);
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   req_type             req;
   logic                rsp_valid;
   rsp_type             rsp;
   logic                csr_we;
   logic [NCOUNT_W-1:0] csr_wdata;

   mst_scoreboard sb;
   int            idle_mode;
   longint        cycles;

   minimum_spanning_tree_kruskal u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial sb = new();

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check(rsp);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic send(req_type r);
      int gap;
      start <= 1'b1;
      req   <= r;
      do @(posedge clock); while (busy);
      sb.note(r);
      gap = 0;
      if (idle_mode == 1 && $urandom_range(99) < 60) gap = $urandom_range(3, 1);
      if (idle_mode == 3 && $urandom_range(99) < 7) gap = $urandom_range(3, 1);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0 || busy) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_nodes(logic [NCOUNT_W-1:0] v);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      sb.set_nodes(v);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_type mk(logic op, int a, int b, int w);
      req_type r;
      r.opcode = op;
      r.end_a  = a[NODE_W-1:0];
      r.end_b  = b[NODE_W-1:0];
      r.weight = w[WEIGHT_W-1:0];
      return r;
   endfunction

   function automatic req_type rand_item();
      req_type r;
      int      e;
      int      span;
      e = sb.n_edges;
      r = mk(OP_LOAD, $urandom_range(31), $urandom_range(31), $urandom_range(65535));
      if (e < 32)       r.opcode = ($urandom_range(1) == 0);
      else if (e < 96)  r.opcode = ($urandom_range(2) == 0);
      else              r.opcode = ($urandom_range(29) == 0);
      span = (sb.nodes < NODE_CAP) ? sb.nodes + 1 : 31;
      if ($urandom_range(3) != 0) begin
         r.end_a = NODE_W'($urandom_range(span > 31 ? 31 : span));
         r.end_b = NODE_W'($urandom_range(span > 31 ? 31 : span));
      end
      case ($urandom_range(7))
         0, 1: r.weight = WEIGHT_W'($urandom_range(3));
         2:    r.weight = $urandom_range(1) ? 16'hffff : 16'h0000;
         default: ;
      endcase
      return r;
   endfunction

   initial begin
      logic [NCOUNT_W-1:0] node_plan [8];
      int overflow;
      node_plan = '{6'd32, 6'd8, 6'd63, 6'd1, 6'd17, 6'd0, 6'd2, 6'd31};
      cycles    = 0;
      reset     = 1'b1;
      start     = 1'b0;
      req       = '0;
      csr_we    = 1'b0;
      csr_wdata = '0;
      idle_mode = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty store, extremes, self loop, ties, node limits
      write_nodes(6'd32);
      send(mk(OP_RUN, 31, 31, 65535));
      send(mk(OP_LOAD, 0, 31, 65535));
      send(mk(OP_LOAD, 31, 0, 0));
      send(mk(OP_LOAD, 5, 5, 1));
      send(mk(OP_LOAD, 1, 2, 0));
      send(mk(OP_LOAD, 2, 1, 0));
      send(mk(OP_LOAD, 0, 0, 7));
      send(mk(OP_LOAD, 0, 1, 65535));
      send(mk(OP_LOAD, 2, 31, 3));
      send(mk(OP_RUN, 0, 0, 0));
      write_nodes(6'd0);
      send(mk(OP_RUN, 0, 0, 0));
      write_nodes(6'd1);
      send(mk(OP_RUN, 0, 0, 0));
      write_nodes(6'd63);
      send(mk(OP_RUN, 0, 0, 0));
      write_nodes(6'd3);
      send(mk(OP_RUN, 31, 0, 65535));

      overflow = 0;
      for (int ph = 0; ph < 8; ph++) begin
         write_nodes(node_plan[ph]);
         idle_mode = ph % 4;
         for (int n = 0; n < 55; ) begin
            if (sb.n_edges >= EDGE_CAP && overflow < 6) begin
               overflow++;
               send(mk(OP_LOAD, $urandom_range(31), $urandom_range(31),
                       $urandom_range(65535)));
               continue;
            end
            send(rand_item());
            n++;
         end
      end
      write_nodes(6'd32);
      idle_mode = 0;
      send(mk(OP_RUN, 0, 0, 0));
      wait_idle();

      $display("runs %0d, edges stored %0d, loads past full %0d, result beats %0d",
               sb.runs, sb.n_edges, sb.ignored_loads, sb.results);
      $display("several node counts from 0 to 63 used, %0d mismatches", sb.errors);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
